[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[hw/rtl/rtp_pkg.sv]
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types and constants for the rotate, translate and project block.
// ----------------------------------------------------------------------------
package rtp_pkg;
  localparam int unsigned VertW   = 16;
  localparam int unsigned OutW    = 32;
  localparam int unsigned IrW     = 48;
  localparam int unsigned NumW    = 64;   // h * |ir|, at most 16 + 45 bits
  localparam int unsigned DenW    = 45;
  localparam int unsigned QuotW   = 50;   // 34 integer bits + 16 fraction bits
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_ROW0 = 3'd0, REG_ROT_ROW1 = 3'd1, REG_ROT_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3, REG_TRANS_Y  = 3'd4, REG_TRANS_Z  = 3'd5,
    REG_PROJ_DIST = 3'd6, REG_SCREEN_OFS = 3'd7
  } cfg_reg_t;

  // Classified work handed from the front end to the divider back end.
  typedef struct packed {
    logic                   bad;      // zero or out of range depth
    logic [NumW-1:0]        num_x;
    logic [NumW-1:0]        num_y;
    logic                   neg_x;
    logic                   neg_y;
    logic [DenW-1:0]        den;
    logic signed [OutW-1:0] depth;
  } work_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;
endpackage

[hw/rtl/rtp_if.sv]
// ----------------------------------------------------------------------------
// rtp_vert_if / rtp_res_if
// Valid/ready channels for vertices and projected results.
// ----------------------------------------------------------------------------
interface rtp_vert_if;
  logic valid;
  logic ready;
  logic signed [15:0] vert_x;
  logic signed [15:0] vert_y;
  logic signed [15:0] vert_z;
  modport source (output valid, vert_x, vert_y, vert_z, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface rtp_res_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_z;
  modport source (output valid, valid_res, screen_x, screen_y, depth_z, input ready);
  modport sink (input valid, valid_res, screen_x, screen_y, depth_z, output ready);
endinterface

[hw/rtl/rtp_front.sv]
// ----------------------------------------------------------------------------
// rtp_front
// Three stage front end: rotate and translate, classify depth, form the
// projection numerators.
// ----------------------------------------------------------------------------
module rtp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   vx,
  input  logic signed [15:0]   vy,
  input  logic signed [15:0]   vz,
  input  logic [47:0]          rot0,
  input  logic [47:0]          rot1,
  input  logic [47:0]          rot2,
  input  logic signed [31:0]   tx,
  input  logic signed [31:0]   ty,
  input  logic signed [31:0]   tz,
  input  logic [15:0]          h,
  output logic                 wk_valid,
  input  logic                 wk_ready,
  output rtp_pkg::work_t       wk
);
  localparam int unsigned IrW = rtp_pkg::IrW;

  logic                  v1_r, v2_r, v3_r;
  logic                  adv;
  logic signed [IrW-1:0] ir0_r, ir1_r, ir2_r;
  logic signed [IrW-1:0] ir0_nxt, ir1_nxt, ir2_nxt;
  logic [IrW-1:0]        m0_r, m1_r, m2_r;
  logic                  s0_r, s1_r, s2_r, bad_r;
  logic [15:0]           h_r;
  rtp_pkg::work_t        wk_r;

  function automatic logic signed [IrW-1:0] dot(input logic [47:0] row,
      input logic signed [15:0] a, input logic signed [15:0] b,
      input logic signed [15:0] c, input logic signed [31:0] t);
    logic signed [IrW-1:0] acc;
    acc = IrW'($signed(row[15:0]) * a) + IrW'($signed(row[31:16]) * b)
        + IrW'($signed(row[47:32]) * c) + ($signed(IrW'(t)) <<< 12);
    return acc;
  endfunction

  function automatic logic [IrW-1:0] magn(input logic signed [IrW-1:0] v);
    return v[IrW-1] ? IrW'(-v) : IrW'(v);
  endfunction

  // The whole pipe moves together; a stalled output holds every stage.
  assign adv      = !v3_r || wk_ready;
  assign in_ready = adv;
  assign ir0_nxt  = dot(rot0, vx, vy, vz, tx);
  assign ir1_nxt  = dot(rot1, vx, vy, vz, ty);
  assign ir2_nxt  = dot(rot2, vx, vy, vz, tz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ir0_r <= ir0_nxt; ir1_r <= ir1_nxt; ir2_r <= ir2_nxt;
      m0_r  <= magn(ir0_r); m1_r <= magn(ir1_r); m2_r <= magn(ir2_r);
      s0_r  <= ir0_r[IrW-1]; s1_r <= ir1_r[IrW-1]; s2_r <= ir2_r[IrW-1];
      // The depth must round into 32 bits, so the top end stops one whole step short.
      bad_r <= (ir2_r == '0) || (ir2_r < -(IrW'(1) <<< 43))
            || (ir2_r > ((IrW'(1) <<< 43) - IrW'(4096)));
      h_r   <= (h == '0) ? 16'd4096 : h;
      wk_r.bad   <= bad_r;
      wk_r.num_x <= 64'(h_r) * 64'(m0_r);
      wk_r.num_y <= 64'(h_r) * 64'(m1_r);
      wk_r.neg_x <= s0_r ^ s2_r;
      wk_r.neg_y <= s1_r ^ s2_r;
      wk_r.den   <= m2_r[44:0];
      // Depth rounded half away from zero from 12 fraction bits.
      wk_r.depth <= 32'(s2_r ? -$signed({1'b0, (m2_r + 48'd2048) >> 12})
                             :  $signed({1'b0, (m2_r + 48'd2048) >> 12}));
    end
  end

  assign wk_valid = v3_r;
  assign wk       = wk_r;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_hold, clk, rst_n, v3_r && !wk_ready, v3_r && $stable(wk_r))
  `ASSERT_IMPLIES(a_rdy, clk, rst_n, !v3_r, in_ready)
  `ASSERT_IMPLIES(a_den, clk, rst_n, v3_r && !wk_r.bad, wk_r.den != '0)
endmodule

[hw/rtl/rtp_queue.sv]
// ----------------------------------------------------------------------------
// rtp_queue
// Small queue decoupling the front end from the divider back end.
// ----------------------------------------------------------------------------
module rtp_queue #(
  parameter int unsigned Depth = rtp_pkg::QueueDepthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rtp_pkg::work_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rtp_pkg::work_t rd_data
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  rtp_pkg::work_t mem_r [Depth];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + AW'(1);
      if (rd) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_cnt, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(Depth))
  `ASSERT_NEXT(a_fill, clk, rst_n, wr && !rd, cnt_r == $past(cnt_r) + (AW+1)'(1))
  `ASSERT_NEXT(a_drain, clk, rst_n, rd && !wr, cnt_r == $past(cnt_r) - (AW+1)'(1))
endmodule

[hw/rtl/rtp_back.sv]
// ----------------------------------------------------------------------------
// rtp_back
// Pipelined restoring dividers for x and y, then offset, range check and
// rounding. One bit of quotient per stage, one item enters per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rtp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wk_valid,
  output logic                wk_ready,
  input  rtp_pkg::work_t      wk,
  input  logic [63:0]         ofs,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                valid_res,
  output logic signed [31:0]  screen_x,
  output logic signed [31:0]  screen_y,
  output logic signed [31:0]  depth_z
);
  localparam int unsigned QW = rtp_pkg::QuotW;   // quotient bits, one per stage
  localparam int unsigned NW = rtp_pkg::NumW;
  localparam int unsigned DW = rtp_pkg::DenW;
  localparam int unsigned EW = NW + 16;          // numerator scaled by 2^16
  localparam int unsigned RW = DW + 1;

  typedef struct packed {
    logic           v;
    logic           bad;
    logic           neg_x, neg_y;
    logic [DW-1:0]  den;
    logic [EW-1:0]  nx, ny;     // remaining dividend bits, shifted out msb first
    logic [RW-1:0]  rx, ry;     // partial remainders
    logic [QW-1:0]  qx, qy;
    logic           ovx, ovy;   // quotient above the stage's reach
    logic signed [31:0] depth;
  } stg_t;

  stg_t st_r [QW+1];
  stg_t st_nxt [QW+1];
  logic adv;

  // Final stage registers.
  logic              ov_r, vres_r;
  logic signed [31:0] sx_r, sy_r, dz_r;

  assign adv      = !ov_r || out_ready;
  assign wk_ready = adv;

  // Leading dividend bits beyond the quotient width must already fall below
  // the divisor, else the integer part is 2^34 or more.
  always_comb begin
    st_nxt[0].v     = wk_valid;
    st_nxt[0].bad   = wk.bad;
    st_nxt[0].neg_x = wk.neg_x;
    st_nxt[0].neg_y = wk.neg_y;
    st_nxt[0].den   = wk.den;
    st_nxt[0].nx    = {wk.num_x, 16'd0} << (EW - QW);
    st_nxt[0].ny    = {wk.num_y, 16'd0} << (EW - QW);
    st_nxt[0].rx    = RW'({wk.num_x, 16'd0} >> QW);
    st_nxt[0].ry    = RW'({wk.num_y, 16'd0} >> QW);
    st_nxt[0].ovx   = (({wk.num_x, 16'd0} >> QW) >= EW'(wk.den));
    st_nxt[0].ovy   = (({wk.num_y, 16'd0} >> QW) >= EW'(wk.den));
    st_nxt[0].qx    = '0;
    st_nxt[0].qy    = '0;
    st_nxt[0].depth = wk.depth;
    for (int i = 1; i <= QW; i++) begin
      logic [RW:0] tx, ty;
      tx = {st_r[i-1].rx, st_r[i-1].nx[EW-1]};
      ty = {st_r[i-1].ry, st_r[i-1].ny[EW-1]};
      st_nxt[i] = st_r[i-1];
      st_nxt[i].nx = st_r[i-1].nx << 1;
      st_nxt[i].ny = st_r[i-1].ny << 1;
      if (tx >= (RW+1)'(st_r[i-1].den)) begin
        st_nxt[i].rx = RW'(tx - (RW+1)'(st_r[i-1].den));
        st_nxt[i].qx = {st_r[i-1].qx[QW-2:0], 1'b1};
      end else begin
        st_nxt[i].rx = RW'(tx);
        st_nxt[i].qx = {st_r[i-1].qx[QW-2:0], 1'b0};
      end
      if (ty >= (RW+1)'(st_r[i-1].den)) begin
        st_nxt[i].ry = RW'(ty - (RW+1)'(st_r[i-1].den));
        st_nxt[i].qy = {st_r[i-1].qy[QW-2:0], 1'b1};
      end else begin
        st_nxt[i].ry = RW'(ty);
        st_nxt[i].qy = {st_r[i-1].qy[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= QW; i++) begin
      if (!rst_n) st_r[i].v <= 1'b0;
      else if (adv) st_r[i] <= st_nxt[i];
    end
  end

  // Offset, range check and rounding.
  function automatic logic [32:0] fin(input logic [QW-1:0] q, input logic neg,
                                      input logic ov, input logic [31:0] o);
    logic signed [52:0] s;
    logic [52:0]        m;
    logic               bad;
    logic [31:0]        r;
    s   = neg ? -$signed({3'b0, q}) : $signed({3'b0, q});
    s   = s + 53'($signed(o));
    bad = ov || q[QW-1] || (s < -(53'sd1 <<< 47))
       || (s > ((53'sd1 <<< 47) - 53'sd65536));
    m   = s[52] ? 53'(-s) : 53'(s);
    m   = (m + 53'd32768) >> 16;
    r   = s[52] ? 32'(-m) : 32'(m);
    return {bad, r};
  endfunction

  logic [32:0] fx, fy;
  assign fx = fin(st_r[QW].qx, st_r[QW].neg_x, st_r[QW].ovx, ofs[31:0]);
  assign fy = fin(st_r[QW].qy, st_r[QW].neg_y, st_r[QW].ovy, ofs[63:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= st_r[QW].v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (st_r[QW].bad || fx[32] || fy[32]) begin
        vres_r <= 1'b0; sx_r <= '0; sy_r <= '0; dz_r <= '0;
      end else begin
        vres_r <= 1'b1; sx_r <= fx[31:0]; sy_r <= fy[31:0]; dz_r <= st_r[QW].depth;
      end
    end
  end

  assign out_valid = ov_r;
  assign valid_res = vres_r;
  assign screen_x  = sx_r;
  assign screen_y  = sy_r;
  assign depth_z   = dz_r;

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_zero, clk, rst_n, ov_r && !vres_r, sx_r == '0 && dz_r == '0)
  `ASSERT_NEXT(a_stall, clk, rst_n, ov_r && !out_ready, ov_r && $stable(sx_r))
  `ASSERT_IMPLIES(a_rdy, clk, rst_n, !ov_r, wk_ready)
endmodule

[hw/rtl/rotate_translate_project.sv]
// ----------------------------------------------------------------------------
// rotate_translate_project
// Rotates and translates a vertex, then projects it onto the screen.
// ----------------------------------------------------------------------------
// Channel | Dir | Transfer fields
// in_     | in  | vert_x, vert_y, vert_z
// out_    | out | valid_res, screen_x, screen_y, depth_z
// cfg_    | in  | cfg_we, cfg_idx, cfg_data (write only)
//
// One vertex per cycle unless the output stalls; data passes 3 front stages,
// the queue, 51 divider stages (an entry stage, then one per quotient bit)
// and one output register. Synchronous reset clears config and control state.
// A stalled output holds the back end; the queue absorbs the front end.
// ----------------------------------------------------------------------------
module rotate_translate_project #(
  parameter int unsigned QueueDepth = rtp_pkg::QueueDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rtp_vert_if.sink                      in_ch,
  rtp_res_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rtp_pkg::CfgIdxW:0]     cfg_idx,
  input  logic [rtp_pkg::CfgW-1:0]      cfg_data
);
  logic [47:0]        rot0_r, rot1_r, rot2_r;
  logic signed [31:0] tx_r, ty_r, tz_r;
  logic [15:0]        h_r;
  logic [63:0]        ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r <= '0; rot1_r <= '0; rot2_r <= '0;
      tx_r <= '0; ty_r <= '0; tz_r <= '0; h_r <= '0; ofs_r <= '0;
    end else if (cfg_we && !cfg_idx[rtp_pkg::CfgIdxW]) begin
      case (rtp_pkg::cfg_reg_t'(cfg_idx[rtp_pkg::CfgIdxW-1:0]))
        rtp_pkg::REG_ROT_ROW0:   rot0_r <= cfg_data[47:0];
        rtp_pkg::REG_ROT_ROW1:   rot1_r <= cfg_data[47:0];
        rtp_pkg::REG_ROT_ROW2:   rot2_r <= cfg_data[47:0];
        rtp_pkg::REG_TRANS_X:    tx_r   <= cfg_data[31:0];
        rtp_pkg::REG_TRANS_Y:    ty_r   <= cfg_data[31:0];
        rtp_pkg::REG_TRANS_Z:    tz_r   <= cfg_data[31:0];
        rtp_pkg::REG_PROJ_DIST:  h_r    <= cfg_data[15:0];
        rtp_pkg::REG_SCREEN_OFS: ofs_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           f_valid, f_ready, b_valid, b_ready;
  rtp_pkg::work_t f_wk, b_wk;

  rtp_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .vx (in_ch.vert_x), .vy (in_ch.vert_y), .vz (in_ch.vert_z),
    .rot0 (rot0_r), .rot1 (rot1_r), .rot2 (rot2_r),
    .tx (tx_r), .ty (ty_r), .tz (tz_r), .h (h_r),
    .wk_valid (f_valid), .wk_ready (f_ready), .wk (f_wk)
  );

  rtp_queue #(.Depth (QueueDepth)) u_queue (
    .clk, .rst_n,
    .wr_valid (f_valid), .wr_ready (f_ready), .wr_data (f_wk),
    .rd_valid (b_valid), .rd_ready (b_ready), .rd_data (b_wk)
  );

  rtp_back u_back (
    .clk, .rst_n,
    .wk_valid (b_valid), .wk_ready (b_ready), .wk (b_wk), .ofs (ofs_r),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .valid_res (out_ch.valid_res), .screen_x (out_ch.screen_x),
    .screen_y (out_ch.screen_y), .depth_z (out_ch.depth_z)
  );
endmodule
